>>> hdl/loa_pkg.sv
// Package: shared types, constants and tables for landmark observation association.
`default_nettype none
package loa_pkg;
    localparam int MAX_LANDMARKS_DEF = 64;
    localparam int CORDIC_STEPS = 17;
    localparam logic signed [19:0] Q_PI = 20'sd205887;
    localparam logic signed [19:0] Q_HALF_PI = 20'sd102944;
    localparam logic signed [19:0] Q_TWO_PI = 20'sd411775;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_ASSOC = 1'b1;

    function automatic logic signed [19:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 20'sd51472;
            5'd1: atan_q16 = 20'sd30386;
            5'd2: atan_q16 = 20'sd16055;
            5'd3: atan_q16 = 20'sd8150;
            5'd4: atan_q16 = 20'sd4091;
            5'd5: atan_q16 = 20'sd2047;
            5'd6: atan_q16 = 20'sd1024;
            5'd7: atan_q16 = 20'sd512;
            5'd8: atan_q16 = 20'sd256;
            5'd9: atan_q16 = 20'sd128;
            5'd10: atan_q16 = 20'sd64;
            5'd11: atan_q16 = 20'sd32;
            5'd12: atan_q16 = 20'sd16;
            5'd13: atan_q16 = 20'sd8;
            5'd14: atan_q16 = 20'sd4;
            5'd15: atan_q16 = 20'sd2;
            5'd16: atan_q16 = 20'sd1;
            default: atan_q16 = 20'sd0;
        endcase
    endfunction

    // queued command between front and back
    typedef struct packed {
        logic               op;
        logic [5:0]         idx;
        logic [15:0]        id;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [18:0] hd;
        logic signed [24:0] ox;
        logic signed [24:0] oy;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic [31:0]        rx;
        logic [31:0]        ry;
        logic               last;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CORDIC, ST_MUL, ST_SUM, ST_SCAN, ST_DRAIN, ST_OUT
    } t_state;
endpackage
`default_nettype wire

>>> hdl/landmark_observation_association.sv
// Top level: landmark observation association.
// Channel | dir | fields (tdata low bit up)
// s_axis  | in  | tdata: entry_index, entry_id, entry_x, entry_y, pose_x, pose_y,
//         |     |   pose_heading, obs_x, obs_y; tuser: opcode; tlast: obs_last
// m_axis  | out | tdata: match_id, map_point_x/y, residual_x_sq/y_sq; tlast: is_last
// cfg     | in  | i_cfg_wr_en/i_cfg_wr_data: landmark_count
// Table write: handled while the back end is idle. Association: CORDIC iterations, transform
// states ST_MUL and ST_SUM, a landmark_count-entry scan (one table read per cycle), then ST_DRAIN and ST_OUT.
// Synchronous active-low reset clears control; table contents undefined until written.
// A two-entry queue parts input from the back end; the output register holds under stall.
`default_nettype none
module landmark_observation_association
    import loa_pkg::*;
#(
    parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [6:0]   i_cfg_wr_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [223:0] s_axis_tdata,  // idx,id,ex,ey,px,py,hd,ox,oy
    input  wire          s_axis_tuser,  // opcode
    input  wire          s_axis_tlast,  // obs_last
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [143:0] m_axis_tdata,  // id,mx,my,rx,ry
    output logic         m_axis_tlast   // is_last
);
    logic [6:0] r_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 7'd1;
        else if (i_cfg_wr_en) r_count <= i_cfg_wr_data;
    end

    t_cmd in_cmd, q_cmd;
    t_res res;
    logic q_valid, q_ready;
    always_comb begin
        in_cmd.op = s_axis_tuser;
        in_cmd.idx = s_axis_tdata[5:0];
        in_cmd.id = s_axis_tdata[21:6];
        in_cmd.ex = s_axis_tdata[53:22];
        in_cmd.ey = s_axis_tdata[85:54];
        in_cmd.px = s_axis_tdata[117:86];
        in_cmd.py = s_axis_tdata[149:118];
        in_cmd.hd = s_axis_tdata[168:150];
        in_cmd.ox = s_axis_tdata[193:169];
        in_cmd.oy = s_axis_tdata[218:194];
        in_cmd.last = s_axis_tlast;
    end

    loa_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(in_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    loa_back #(.MAX_LANDMARKS(MAX_LANDMARKS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_count(r_count),
        .i_valid(q_valid), .o_ready(q_ready), .i_cmd(q_cmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = {res.ry, res.rx, res.my, res.mx, res.id};
    assign m_axis_tlast = res.last;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_cnt_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> r_count == 7'd1)
        else $error("count reset");
endmodule
`default_nettype wire

>>> hdl/loa_front.sv
// Front end: a two-entry command queue.
`default_nettype none
module loa_front
    import loa_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_cmd   i_cmd,
    output logic        o_valid,
    input  wire         i_ready,
    output t_cmd        o_cmd
);
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> hdl/loa_back.sv
// Back end: table writes, CORDIC, transform and nearest-landmark scan.
`default_nettype none
module loa_back
    import loa_pkg::*;
#(
    parameter int MAX_LANDMARKS = MAX_LANDMARKS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire  [6:0]  i_count,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire t_cmd   i_cmd,
    output logic        o_valid,
    input  wire         i_ready,
    output t_res        o_res
);
    localparam int AW = $clog2(MAX_LANDMARKS);
    localparam int CW = $clog2(MAX_LANDMARKS + 1);

    logic [15:0]        mem_id [MAX_LANDMARKS];
    logic signed [31:0] mem_x  [MAX_LANDMARKS];
    logic signed [31:0] mem_y  [MAX_LANDMARKS];

    t_state r_st, n_st;
    t_cmd   r_c;
    logic signed [33:0] r_cx, r_cy;
    logic signed [19:0] r_z;
    logic [4:0] r_k;
    logic r_neg;
    logic signed [17:0] r_s, r_c17;
    logic signed [42:0] r_p0, r_p1, r_p2, r_p3;
    logic signed [31:0] r_mx, r_my;
    logic [CW-1:0] r_n, r_ai;
    logic r_rdv;
    logic [AW-1:0] r_ri;
    logic signed [31:0] r_rx, r_ry;
    logic [32:0] r_bd;
    logic [31:0] r_brx, r_bry;
    logic [AW-1:0] r_bi, r_ri_d;
    logic r_first;
    logic [15:0] r_oid;
    t_res r_out;
    logic r_ov;

    // accepted command -> folded angle
    logic signed [19:0] th0, th1, th2;
    logic fneg;
    always_comb begin
        th0 = {i_cmd.hd[18], i_cmd.hd};
        th1 = th0;
        if (th0 > Q_PI) th1 = th0 - Q_TWO_PI;
        else if (th0 < -Q_PI) th1 = th0 + Q_TWO_PI;
        th2 = th1;
        fneg = 1'b0;
        if (th1 > Q_HALF_PI) begin
            th2 = th1 - Q_PI;
            fneg = 1'b1;
        end else if (th1 < -Q_HALF_PI) begin
            th2 = th1 + Q_PI;
            fneg = 1'b1;
        end
    end

    function automatic logic signed [17:0] rnd_clamp(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [20:0] r;
        t = {v[33], v} + 35'sd8192;
        r = t[34:14];
        if (r > 21'sd65536) rnd_clamp = 18'sd65536;
        else if (r < -21'sd65536) rnd_clamp = -18'sd65536;
        else rnd_clamp = r[17:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
        if (v > 45'sd2147483647) sat32 = 32'h7fffffff;
        else if (v < -45'sd2147483648) sat32 = 32'h80000000;
        else sat32 = v[31:0];
    endfunction

    function automatic logic [31:0] sq_q16(input logic signed [32:0] d);
        logic [32:0] a;
        logic [47:0] p;
        a = d[32] ? 33'(-d) : 33'(d);
        p = a[23:0] * a[23:0];
        if (a >= 33'd16777216) sq_q16 = 32'hffffffff;
        else sq_q16 = p[47:16];
    endfunction

    logic signed [33:0] sh_x, sh_y;
    assign sh_x = r_cx >>> r_k;
    assign sh_y = r_cy >>> r_k;

    logic [31:0] rxs, rys;
    logic [32:0] dsum;
    assign rxs = sq_q16({r_rx[31], r_rx} - {r_mx[31], r_mx});
    assign rys = sq_q16({r_ry[31], r_ry} - {r_my[31], r_my});
    assign dsum = {1'b0, rxs} + {1'b0, rys};

    logic out_free;
    assign out_free = !r_ov || i_ready;
    assign o_ready = (r_st == ST_IDLE);
    assign o_valid = r_ov;
    assign o_res = r_out;

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:   if (i_valid && i_cmd.op == OP_ASSOC) n_st = ST_CORDIC;
            ST_CORDIC: if (r_k == 5'(CORDIC_STEPS - 1)) n_st = ST_MUL;
            ST_MUL:    n_st = ST_SUM;
            ST_SUM:    n_st = ST_SCAN;
            ST_SCAN:   if (r_ai == r_n - CW'(1)) n_st = ST_DRAIN;
            ST_DRAIN:  n_st = ST_OUT;
            ST_OUT:    if (out_free) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_valid && i_cmd.op == OP_WRITE &&
            int'(i_cmd.idx) < MAX_LANDMARKS) begin
            mem_id[AW'(i_cmd.idx)] <= i_cmd.id;
            mem_x[AW'(i_cmd.idx)] <= i_cmd.ex;
            mem_y[AW'(i_cmd.idx)] <= i_cmd.ey;
        end
        r_rx <= mem_x[r_ri];
        r_ry <= mem_y[r_ri];
        r_oid <= mem_id[r_bi];
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_c <= i_cmd;
                r_cx <= CORDIC_GAIN;
                r_cy <= '0;
                r_z <= th2;
                r_neg <= fneg;
                r_k <= '0;
                if (i_count == 7'd0) r_n <= CW'(1);
                else if (int'(i_count) > MAX_LANDMARKS) r_n <= CW'(MAX_LANDMARKS);
                else r_n <= CW'(i_count);
            end
            ST_CORDIC: begin
                if (!r_z[19]) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_z <= r_z - atan_q16(r_k);
                end else begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_z <= r_z + atan_q16(r_k);
                end
                r_k <= r_k + 5'd1;
                if (r_k == 5'(CORDIC_STEPS - 1)) begin
                    if (r_z[19]) begin
                        r_s <= r_neg ? -rnd_clamp(r_cy - sh_x) : rnd_clamp(r_cy - sh_x);
                        r_c17 <= r_neg ? -rnd_clamp(r_cx + sh_y) : rnd_clamp(r_cx + sh_y);
                    end else begin
                        r_s <= r_neg ? -rnd_clamp(r_cy + sh_x) : rnd_clamp(r_cy + sh_x);
                        r_c17 <= r_neg ? -rnd_clamp(r_cx - sh_y) : rnd_clamp(r_cx - sh_y);
                    end
                end
            end
            ST_MUL: begin
                r_p0 <= 43'(r_c17) * 43'(r_c.ox);
                r_p1 <= 43'(r_s) * 43'(r_c.oy);
                r_p2 <= 43'(r_s) * 43'(r_c.ox);
                r_p3 <= 43'(r_c17) * 43'(r_c.oy);
            end
            ST_SUM: begin
                r_mx <= sat32(45'(((45'(r_p0) - 45'(r_p1) + 45'sd32768) >>> 16))
                              + 45'(r_c.px));
                r_my <= sat32(45'(((45'(r_p2) + 45'(r_p3) + 45'sd32768) >>> 16))
                              + 45'(r_c.py));
                r_ai <= '0;
                r_ri <= '0;
                r_first <= 1'b1;
            end
            default: ;
        endcase
        // scan: issue reads at r_ri, evaluate in the next cycle
        if (r_st == ST_SUM || r_st == ST_SCAN) begin
            if (r_st == ST_SCAN) begin
                r_ai <= r_ai + CW'(1);
                r_ri <= r_ri + AW'(1);
            end
            r_ri_d <= r_ri;
            r_rdv <= (r_st == ST_SCAN);
        end else if (r_st == ST_DRAIN) begin
            r_rdv <= 1'b0;
        end
        if (r_rdv && (r_first || dsum < r_bd)) begin
            r_first <= 1'b0;
            r_bd <= dsum;
            r_brx <= rxs;
            r_bry <= rys;
            r_bi <= r_ri_d;
        end
    end

    // table id for the winner is read while in ST_OUT's first cycle
    logic r_outw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
            r_outw <= 1'b0;
        end else begin
            r_st <= n_st;
            r_outw <= (r_st == ST_DRAIN);
            if (r_st == ST_OUT && out_free) r_ov <= 1'b1;
            else if (r_ov && i_ready) r_ov <= 1'b0;
        end
        if (r_st == ST_OUT && out_free) begin
            r_out.id <= r_outw ? mem_id[r_bi] : r_oid;
            r_out.mx <= r_mx;
            r_out.my <= r_my;
            r_out.rx <= r_brx;
            r_out.ry <= r_bry;
            r_out.last <= r_c.last;
        end
    end
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the landmark nearest-neighbor association block.
module testbench;
    import loa_pkg::*;

    localparam int N_SLOTS  = 64;
    localparam int WDOG_MAX = 6000;
    localparam int SETTLE   = 120;

    typedef struct {
        logic               op;
        logic [5:0]         idx;
        logic [15:0]        id;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [18:0] hd;
        logic signed [24:0] ox;
        logic signed [24:0] oy;
        logic               last;
    } t_obs_item;

    typedef struct {
        logic [15:0] id;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] rx;
        logic [31:0] ry;
        logic        last;
    } t_match;

    class t_assoc_scoreboard;
        logic [15:0] lm_id[N_SLOTS];
        longint      lm_x[N_SLOTS];
        longint      lm_y[N_SLOTS];
        int          scan_count = 1;
        t_match      pending_q[$];
        int          errors = 0;

        function void sin_cos(longint th, output longint s, output longint c);
            longint x, y, z, nx;
            int     atn[CORDIC_STEPS];
            bit     neg;
            atn = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                    128, 64, 32, 16, 8, 4, 2, 1};
            x = 652032874;
            y = 0;
            neg = 0;
            if (th > 205887) th -= 411775;
            if (th < -205887) th += 411775;
            if (th > 102944) begin
                th -= 205887;
                neg = 1;
            end else if (th < -102944) begin
                th += 205887;
                neg = 1;
            end
            z = th;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= atn[i];
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += atn[i];
                end
                x = nx;
            end
            x = (x + 8192) >>> 14;
            y = (y + 8192) >>> 14;
            if (x > 65536) x = 65536;
            if (x < -65536) x = -65536;
            if (y > 65536) y = 65536;
            if (y < -65536) y = -65536;
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint square_q16(longint d);
            longint a;
            a = (d < 0) ? -d : d;
            if (a >= (64'sd1 << 24)) return 64'sd4294967295;
            a = (a * a) >>> 16;
            return (a > 64'sd4294967295) ? 64'sd4294967295 : a;
        endfunction

        function void set_count(int v);
            scan_count = v;
        endfunction

        function void note_input(t_obs_item it);
            longint s, c, ox, oy, mx, my, rx, ry, d, best_d, best_rx, best_ry;
            int     n, best;
            t_match m;
            if (it.op == OP_WRITE) begin
                lm_id[it.idx] = it.id;
                lm_x[it.idx] = it.ex;
                lm_y[it.idx] = it.ey;
                return;
            end
            sin_cos(longint'(it.hd), s, c);
            ox = it.ox;
            oy = it.oy;
            mx = sat32(((c * ox - s * oy + 32768) >>> 16) + longint'(it.px));
            my = sat32(((s * ox + c * oy + 32768) >>> 16) + longint'(it.py));
            n = scan_count;
            if (n < 1) n = 1;
            if (n > N_SLOTS) n = N_SLOTS;
            best = 0;
            best_d = 0;
            best_rx = 0;
            best_ry = 0;
            for (int i = 0; i < n; i++) begin
                rx = square_q16(lm_x[i] - mx);
                ry = square_q16(lm_y[i] - my);
                d = rx + ry;
                if (i == 0 || d < best_d) begin
                    best = i;
                    best_d = d;
                    best_rx = rx;
                    best_ry = ry;
                end
            end
            m.id = lm_id[best];
            m.mx = mx[31:0];
            m.my = my[31:0];
            m.rx = best_rx[31:0];
            m.ry = best_ry[31:0];
            m.last = it.last;
            pending_q = {pending_q, m};
        endfunction

        function void check_result(t_match got);
            t_match e;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: id %0h", got.id);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (got.id !== e.id) begin
                $error("match_id exp %0h got %0h", e.id, got.id);
                errors++;
            end
            if (got.mx !== e.mx) begin
                $error("map_point_x exp %0h got %0h", e.mx, got.mx);
                errors++;
            end
            if (got.my !== e.my) begin
                $error("map_point_y exp %0h got %0h", e.my, got.my);
                errors++;
            end
            if (got.rx !== e.rx) begin
                $error("residual_x_sq exp %0h got %0h", e.rx, got.rx);
                errors++;
            end
            if (got.ry !== e.ry) begin
                $error("residual_y_sq exp %0h got %0h", e.ry, got.ry);
                errors++;
            end
            if (got.last !== e.last) begin
                $error("is_last exp %0b got %0b", e.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_q.size();
        endfunction
    endclass

    logic           i_clk = 0;
    logic           i_rst_n = 0;
    logic           i_cfg_wr_en = 0;
    logic [6:0]     i_cfg_wr_data = '0;
    logic           s_axis_tvalid = 0;
    logic           s_axis_tready;
    logic [223:0]   s_axis_tdata = '0;
    logic           s_axis_tuser = 0;
    logic           s_axis_tlast = 0;
    logic           m_axis_tvalid;
    logic           m_axis_tready = 0;
    logic [143:0]   m_axis_tdata;
    logic           m_axis_tlast;

    t_assoc_scoreboard sb = new();
    t_obs_item       cur_item;
    bit              hold_req = 0;
    bit              no_idle = 0;
    int              quiet_cycles = 0;

    landmark_observation_association i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // input and output transaction monitors, plus stall watchdog
    always @(posedge i_clk) begin
        t_match r;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_input(cur_item);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            r.id = m_axis_tdata[15:0];
            r.mx = m_axis_tdata[47:16];
            r.my = m_axis_tdata[79:48];
            r.rx = m_axis_tdata[111:80];
            r.ry = m_axis_tdata[143:112];
            r.last = m_axis_tlast;
            sb.check_result(r);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result receiver with random back-pressure
    initial begin
        int w;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                w = 400;
                hold_req = 0;
            end else begin
                w = no_idle ? 0 : $urandom_range(0, 17);
            end
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send(t_obs_item it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.last;
        s_axis_tdata <= {5'd0, it.oy, it.ox, it.hd, it.py, it.px,
                         it.ey, it.ex, it.id, it.idx};
        cur_item <= it;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(int v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= v[6:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        sb.set_count(v);
    endtask

    function automatic t_obs_item make_write(int idx, bit wide);
        t_obs_item it;
        it = '{default: '0};
        it.op = OP_WRITE;
        it.idx = idx[5:0];
        it.id = 16'($urandom);
        it.ex = wide ? $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        it.ey = wide ? $urandom : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        it.px = $urandom;
        it.py = $urandom;
        it.hd = 19'($urandom);
        it.ox = 25'($urandom);
        it.oy = 25'($urandom);
        it.last = 1'($urandom);
        return it;
    endfunction

    function automatic t_obs_item make_assoc(bit wide);
        t_obs_item it;
        it = '{default: '0};
        it.op = OP_ASSOC;
        it.idx = 6'($urandom);
        it.id = 16'($urandom);
        it.ex = $urandom;
        it.ey = $urandom;
        it.last = 1'($urandom);
        if (wide) begin
            it.px = $urandom;
            it.py = $urandom;
            it.hd = 19'($urandom);
            it.ox = 25'($urandom);
            it.oy = 25'($urandom);
        end else begin
            it.px = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            it.py = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            it.hd = 19'($signed($urandom_range(0, 411774)) - 205887);
            it.ox = 25'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            it.oy = 25'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        end
        return it;
    endfunction

    initial begin
        t_obs_item it;
        int        counts[6];
        logic signed [18:0] hds[10];
        counts = '{64, 1, 0, 100, 33, 64};
        hds = '{19'sd0, 19'sd205887, -19'sd205887, 19'sd102944, -19'sd102944,
                19'sd102945, -19'sd102945, 19'sd262143, 19'sh40000, 19'sd51472};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // fill every slot so no scan reads an unwritten entry
        for (int i = 0; i < N_SLOTS; i++) begin
            it = make_write(i, i >= 60);
            if (i == 0) begin
                it.id = 16'h0000;
                it.ex = 0;
                it.ey = 0;
            end
            if (i == 1) begin
                // duplicate of slot 0 position: tie goes to slot 0
                it.id = 16'hffff;
                it.ex = 0;
                it.ey = 0;
            end
            if (i == 2) begin
                it.ex = 32'sh7fffffff;
                it.ey = 32'sh80000000;
            end
            send(it);
        end
        drain_and_settle();
        write_count(64);

        // heading corners, saturating pose and observation extremes
        foreach (hds[k]) begin
            it = make_assoc(0);
            it.hd = hds[k];
            it.last = k[0];
            if (k == 7) begin
                it.px = 32'sh7fffffff;
                it.py = 32'sh80000000;
                it.ox = 25'sd8388608;
                it.oy = -25'sd8388608;
            end
            if (k == 8) begin
                it.px = 32'sh80000000;
                it.py = 32'sh7fffffff;
                it.ox = 25'sh0ffffff;
                it.oy = 25'sh1000000;
            end
            if (k == 0) begin
                it.px = 0;
                it.py = 0;
                it.ox = 0;
                it.oy = 0;
            end
            send(it);
        end

        for (int p = 0; p < 6; p++) begin
            drain_and_settle();
            write_count(counts[p]);
            no_idle = (p == 3);
            if (p == 2) hold_req = 1;
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 4) == 0)
                    it = make_write($urandom_range(0, 63), $urandom_range(0, 9) == 0);
                else
                    it = make_assoc($urandom_range(0, 9) == 0);
                send(it);
            end
        end
        no_idle = 0;

        drain_and_settle();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> files.f
hdl/loa_pkg.sv
hdl/loa_front.sv
hdl/loa_back.sv
hdl/landmark_observation_association.sv
bench/testbench.sv
